### hw/rtl/pfbb_pkg.sv
package pfbb_pkg;

  localparam int FRAME_W     = 128;
  localparam int FRAME_H     = 64;
  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int WIDE_ADDR_W = 14;
  localparam int CFG_IDX_W   = 3;
  localparam int KIND_W      = 2;
  localparam int ROW_W       = 5;

  localparam logic [7:0] FULL_MASK = 8'hFF;
  localparam logic [7:0] BYTE_BITS = 8'd8;

  localparam logic [KIND_W-1:0] KIND_BLIT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_POS_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BMP_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BMP_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_BITS = 3'd5;

  typedef struct packed {
    logic load_item;
    logic calc;
    logic mem_rd;
    logic mem_acc;
    logic slot;
    logic clr_step;
    logic load_out;
  } pfbb_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic en1;
  } pfbb_sts_t;

  function automatic logic [7:0] shl8(input logic [7:0] v, input logic [7:0] s);
    return (s >= BYTE_BITS) ? 8'd0 : 8'(v << s[2:0]);
  endfunction

  function automatic logic [7:0] shr8(input logic [7:0] v, input logic [7:0] s);
    return (s >= BYTE_BITS) ? 8'd0 : 8'(v >> s[2:0]);
  endfunction

endpackage

### hw/rtl/pfbb_if.sv
interface pfbb_in_if;
  import pfbb_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [7:0]          pixel_byte;
  logic [7:0]          byte_col;
  logic [ROW_W-1:0]    byte_row;
  logic [ADDR_W-1:0]   address;
  modport source (output valid, kind, pixel_byte, byte_col, byte_row, address, input ready);
  modport sink   (input valid, kind, pixel_byte, byte_col, byte_row, address, output ready);
endinterface

interface pfbb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [1:0] bytes_written;
  modport source (output valid, read_data, bytes_written, input ready);
  modport sink   (input valid, read_data, bytes_written, output ready);
endinterface

interface pfbb_cfg_if;
  import pfbb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/pfbb_ctrl.sv
module pfbb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  pfbb_pkg::pfbb_sts_t sts_i,
  output pfbb_pkg::pfbb_cmd_t cmd_o
);
  import pfbb_pkg::*;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_CALC  = 8'b0000_0100,
    ST_RD0   = 8'b0000_1000,
    ST_WR0   = 8'b0001_0000,
    ST_RD1   = 8'b0010_0000,
    ST_WR1   = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_RD0;
      end
      ST_RD0: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = ST_WR0;
      end
      ST_WR0: begin
        cmd_o.mem_acc = 1'b1;
        state_d       = sts_i.en1 ? ST_RD1 : ST_DONE;
      end
      ST_RD1: begin
        cmd_o.mem_rd = 1'b1;
        cmd_o.slot   = 1'b1;
        state_d      = ST_WR1;
      end
      ST_WR1: begin
        cmd_o.mem_acc = 1'b1;
        cmd_o.slot    = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### hw/rtl/pfbb_datapath.sv
module pfbb_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pfbb_pkg::pfbb_cmd_t              cmd_i,
  output pfbb_pkg::pfbb_sts_t              sts_o,
  input  logic                             cfg_we_i,
  input  logic [pfbb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [7:0]                       cfg_data_i,
  input  logic [pfbb_pkg::KIND_W-1:0]      kind_i,
  input  logic [7:0]                       pixel_byte_i,
  input  logic [7:0]                       byte_col_i,
  input  logic [pfbb_pkg::ROW_W-1:0]       byte_row_i,
  input  logic [pfbb_pkg::ADDR_W-1:0]      address_i,
  output logic [7:0]                       read_data_o,
  output logic [1:0]                       bytes_written_o
);
  import pfbb_pkg::*;

  logic [7:0] pos_x_q, pos_y_q, bmp_width_q, bmp_height_q, offset_y_q;
  logic       invert_q;
  logic [ADDR_W-1:0] clr_cnt_q;

  logic [KIND_W-1:0] kind_q;
  logic [7:0]        pix_q, col_q;
  logic [ROW_W-1:0]  row_q;
  logic [ADDR_W-1:0] addr_q;

  logic [ADDR_W-1:0] addr0_q, addr1_q;
  logic [7:0]        v0_q, v1_q, rdata_q, rd_res_q, out_rd_q;
  logic              wr0_q, en1_q, zero_q, rdk_q;
  logic [1:0]        cnt_q, out_cnt_q;

  logic [7:0] y, edge_row, py, pn, xb, mask, b, v0, v1;
  logic [2:0] off;
  logic       oy_nz, skip_rc, skip_off, skip_x, ok, py_in, pn_in, a0_ok, a1_ok;
  logic       en0_b, en1_b;
  logic [WIDE_ADDR_W-1:0] wa0, wa1;

  logic [7:0] mem_q [STORE_DEPTH];
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  logic [7:0]        mem_wdata;

  always_comb begin
    y        = pos_y_q - offset_y_q;
    off      = y[2:0];
    edge_row = pos_y_q + bmp_height_q;
    py       = {row_q, 3'b000} + y;
    pn       = py + BYTE_BITS;
    xb       = col_q + pos_x_q;
    oy_nz    = offset_y_q != 8'd0;
    skip_rc  = (row_q >= bmp_height_q[7:3]) || (col_q >= bmp_width_q);
    skip_off = oy_nz && ((pn < pos_y_q) || (pn > 8'(FRAME_H)) || (py > edge_row));
    skip_x   = xb >= 8'(FRAME_W);
    ok       = (kind_q == KIND_BLIT) && !skip_rc && !skip_off && !skip_x;
    priority if (!oy_nz)          mask = FULL_MASK;
    else if (py < pos_y_q)        mask = shl8(FULL_MASK, pos_y_q - py);
    else if (pn > edge_row)       mask = shr8(FULL_MASK, pn - edge_row);
    else                          mask = FULL_MASK;
    b      = (invert_q ? ~pix_q : pix_q) & mask;
    v0     = shl8(b, {5'd0, off});
    v1     = shr8(b, BYTE_BITS - {5'd0, off});
    wa0    = WIDE_ADDR_W'(xb) + WIDE_ADDR_W'(py[7:3]) * WIDE_ADDR_W'(FRAME_W);
    wa1    = WIDE_ADDR_W'(xb) + WIDE_ADDR_W'(pn[7:3]) * WIDE_ADDR_W'(FRAME_W);
    a0_ok  = wa0 < WIDE_ADDR_W'(STORE_DEPTH);
    a1_ok  = wa1 < WIDE_ADDR_W'(STORE_DEPTH);
    py_in  = py < 8'(FRAME_H);
    pn_in  = pn < 8'(FRAME_H);
    en0_b  = ok && py_in && a0_ok;
    en1_b  = ok && !((off == 3'd0) && py_in) && pn_in && a1_ok;
  end

  assign mem_addr  = cmd_i.clr_step ? clr_cnt_q : (cmd_i.slot ? addr1_q : addr0_q);
  assign mem_we    = cmd_i.clr_step || (cmd_i.mem_acc && (cmd_i.slot ? en1_q : wr0_q));
  assign mem_wdata = (cmd_i.clr_step || zero_q) ? 8'd0
                   : (rdata_q | (cmd_i.slot ? v1_q : v0_q));

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wdata;
    if (cmd_i.mem_rd) rdata_q <= mem_q[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q      <= '0;
      pos_y_q      <= '0;
      bmp_width_q  <= '0;
      bmp_height_q <= '0;
      offset_y_q   <= '0;
      invert_q     <= 1'b0;
      clr_cnt_q    <= '0;
    end else begin
      if (cmd_i.clr_step) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_POS_X:       pos_x_q      <= cfg_data_i;
          CFG_POS_Y:       pos_y_q      <= cfg_data_i;
          CFG_BMP_WIDTH:   bmp_width_q  <= cfg_data_i;
          CFG_BMP_HEIGHT:  bmp_height_q <= cfg_data_i;
          CFG_OFFSET_Y:    offset_y_q   <= cfg_data_i;
          CFG_INVERT_BITS: invert_q     <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      kind_q <= kind_i;
      pix_q  <= pixel_byte_i;
      col_q  <= byte_col_i;
      row_q  <= byte_row_i;
      addr_q <= address_i;
    end
    if (cmd_i.calc) begin
      addr0_q  <= (kind_q == KIND_BLIT) ? wa0[ADDR_W-1:0] : addr_q;
      addr1_q  <= wa1[ADDR_W-1:0];
      v0_q     <= v0;
      v1_q     <= v1;
      wr0_q    <= en0_b || (kind_q == KIND_CLEAR);
      en1_q    <= en1_b;
      zero_q   <= kind_q == KIND_CLEAR;
      rdk_q    <= kind_q == KIND_READ;
      cnt_q    <= {1'b0, en0_b} + {1'b0, en1_b};
      rd_res_q <= 8'd0;
    end
    if (cmd_i.mem_acc && !cmd_i.slot && rdk_q) rd_res_q <= rdata_q;
    if (cmd_i.load_out) begin
      out_rd_q  <= rd_res_q;
      out_cnt_q <= cnt_q;
    end
  end

  assign sts_o.clr_last = clr_cnt_q == {ADDR_W{1'b1}};
  assign sts_o.en1      = en1_q;

  assign read_data_o     = out_rd_q;
  assign bytes_written_o = out_cnt_q;

endmodule

### hw/rtl/page_framebuffer_bitmap_blit.sv
// page-mode monochrome bitmap blit engine with a 1024 byte frame store
// each store byte holds eight vertical pixels, lsb at top, at col + page * frame width
// in_i: one item per transfer, kind 0 blit byte, 1 read store byte, 2 clear store byte
// out_o: one result per item, read_data for reads, bytes_written for blits
// cfg_i: register writes by index, always ready; the user must write only while the block is idle, it is not enforced
// an item is accepted in idle, then a calc state and a read state and write state of
// the single-port store for the first byte, another read and write state pair when a
// blit touches two pages, then the result enters the output register from done
// items are taken one at a time, a new item only after the last one has left the
// done state, set by the read-modify-write of the single-port store
// a new item is accepted while the previous result still waits in the output
// register; when the receiver stalls the next result waits in the done state
// and the payload on out_o holds until the transfer
// after reset the store is swept to zero, one byte a cycle, over all 1024 bytes,
// and no item is accepted until the sweep ends; config registers reset to zero
module page_framebuffer_bitmap_blit (
  input logic       clk_i,
  input logic       rst_ni,
  pfbb_in_if.sink   in_i,
  pfbb_cfg_if.sink  cfg_i,
  pfbb_out_if.source out_o
);
  import pfbb_pkg::*;

  pfbb_cmd_t cmd;
  pfbb_sts_t sts;

  assign cfg_i.ready = 1'b1;

  pfbb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pfbb_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_i.valid),
    .cfg_idx_i       (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .kind_i          (in_i.kind),
    .pixel_byte_i    (in_i.pixel_byte),
    .byte_col_i      (in_i.byte_col),
    .byte_row_i      (in_i.byte_row),
    .address_i       (in_i.address),
    .read_data_o     (out_o.read_data),
    .bytes_written_o (out_o.bytes_written)
  );

endmodule

### hw/rtl/pfbb_checker.sv
module pfbb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] read_data_i,
  input logic [1:0] bytes_written_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(read_data_i)
      && $stable(bytes_written_i))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item taken while one is at work");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> bytes_written_i != 2'd3)
    else $error("bytes written out of range");

  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (read_data_i == 8'd0) || (bytes_written_i == 2'd0))
    else $error("read data and write count both set");

endmodule

bind page_framebuffer_bitmap_blit pfbb_checker u_pfbb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .read_data_i     (out_o.read_data),
  .bytes_written_i (out_o.bytes_written)
);
